>>> rtl/ptla_pkg.sv
// Shared types and codes for the peer table with ageing and LRU eviction.
// No dependencies; imported by every module of the block.
package ptla_pkg;

  // Operation codes after classification
  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_SWEEP  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Entry sources
  localparam logic [1:0] ORG_ANNOUNCE = 2'd0;
  localparam logic [1:0] ORG_EXCHANGE = 2'd1;
  localparam logic [1:0] ORG_STATIC   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_INSERT  = 3'd1;
  localparam logic [2:0] ST_EVICT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_RATELIM = 3'd4;
  localparam logic [2:0] ST_SWEPT   = 3'd5;
  localparam logic [2:0] ST_READ    = 3'd6;

  // Configuration register indexes
  localparam logic CFG_EXPIRY = 1'b0;
  localparam logic CFG_GAP    = 1'b1;

  localparam logic [31:0] EXPIRY_RST = 32'd120000;
  localparam logic [31:0] GAP_RST    = 32'd100;

  // One classified item as held in the queue between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [15:0] port;
    logic [1:0]  origin;
    logic [31:0] now;
    logic [7:0]  rslot;
  } item_t;

endpackage

>>> rtl/ptla_front.sv
// Front end: takes input beats, classifies them and queues them for the back end.
// Depends on ptla_pkg.
module ptla_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_kind,
  input  logic [31:0]    in_peer_address,
  input  logic [15:0]    in_peer_port,
  input  logic [1:0]     in_origin_kind,
  input  logic [31:0]    in_now_ticks,
  input  logic [7:0]     in_read_slot,
  output logic           q_valid,
  output ptla_pkg::item_t q_item,
  input  logic           q_pop
);
  import ptla_pkg::*;

  item_t       fifo_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  item_t       cls;

  // classify: kind three reads, origin three is an exchange
  always_comb begin
    cls.op     = (in_kind == OP_UPSERT) ? OP_UPSERT :
                 (in_kind == OP_SWEEP) ? OP_SWEEP : OP_READ;
    cls.addr   = in_peer_address;
    cls.port   = in_peer_port;
    cls.origin = (in_origin_kind == 2'd3) ? ORG_EXCHANGE : in_origin_kind;
    cls.now    = in_now_ticks;
    cls.rslot  = in_read_slot;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  // two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (cnt_r != 2'd0)) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> in_stall) else $error("full queue not stalling");

endmodule

>>> rtl/ptla_back.sv
// Back end: table memory, slot scan engine, configuration and result register.
// Depends on ptla_pkg.
module ptla_back #(
  parameter int PEER_SLOTS = 256,
  parameter int TIME_BITS  = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            q_valid,
  input  ptla_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_status,
  output logic [7:0]      out_slot,
  output logic [31:0]     out_entry_address,
  output logic [15:0]     out_entry_port,
  output logic [1:0]      out_entry_origin,
  output logic            out_entry_valid,
  output logic [8:0]      out_active_count
);
  import ptla_pkg::*;

  localparam int SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CW = $clog2(PEER_SLOTS + 1);
  localparam int EW = 32 + 16 + 2 + TIME_BITS;
  localparam logic [CW-1:0] NSLOTS = CW'(PEER_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  // entry memory: {address, port, origin, stamp}
  logic [EW-1:0]         mem [PEER_SLOTS];
  logic [EW-1:0]         mem_q_r;
  logic                  act_q_r;
  logic [PEER_SLOTS-1:0] active_r;

  logic [1:0]     state_r, state_nxt;
  item_t          cur_r, cur_nxt;
  logic [31:0]    expiry_r, gap_r;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [CW-1:0]  live_r, live_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           p_vld_r, p_vld_nxt;
  logic [SW-1:0]  p_idx_r, p_idx_nxt;
  logic           free_fnd_r, free_fnd_nxt, vic_fnd_r, vic_fnd_nxt;
  logic [SW-1:0]  free_idx_r, free_idx_nxt, vic_idx_r, vic_idx_nxt;
  logic [TIME_BITS-1:0] vic_age_r, vic_age_nxt;

  logic [SW-1:0]  rd_addr;
  logic           mem_we;
  logic [SW-1:0]  mem_wa;
  logic           act_set, act_clr;
  logic [SW-1:0]  act_idx;

  logic           emit;
  logic [2:0]     e_status;
  logic [SW-1:0]  e_slot_idx;
  logic           e_slot_use;
  logic           e_entry;

  logic [31:0]    rs_ext;
  logic           rs_in;
  logic [TIME_BITS-1:0] now_t, stamp_q, age_q, ann_age;
  logic [63:0]    now_ext;
  logic [31:0]    q_addr;
  logic [15:0]    q_port;
  logic [1:0]     q_org;
  logic [EW-1:0]  wr_data;
  logic           out_valid_r;
  logic [31:0]    slot_ext;
  logic [31:0]    live_ext;

  // field views
  assign rs_ext  = {24'd0, cur_r.rslot};
  assign rs_in   = rs_ext < 32'(PEER_SLOTS);
  assign now_ext = {32'd0, cur_r.now};
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign q_addr  = mem_q_r[EW-1 -: 32];
  assign q_port  = mem_q_r[EW-33 -: 16];
  assign q_org   = mem_q_r[TIME_BITS +: 2];
  assign stamp_q = mem_q_r[TIME_BITS-1:0];
  assign age_q   = now_t - stamp_q;
  assign ann_age = now_t - last_r;
  assign wr_data = {cur_r.addr, cur_r.port, cur_r.origin, now_t};

  // memory read address: scan counter while scanning, else the slot of the next item
  always_comb begin
    logic [31:0] qs_ext;
    qs_ext  = {24'd0, q_item.rslot};
    rd_addr = (state_r == S_SCAN) ? cnt_r[SW-1:0] : qs_ext[SW-1:0];
  end

  // control
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    last_nxt     = last_r;
    live_nxt     = live_r;
    cnt_nxt      = cnt_r;
    p_vld_nxt    = 1'b0;
    p_idx_nxt    = p_idx_r;
    free_fnd_nxt = free_fnd_r;
    free_idx_nxt = free_idx_r;
    vic_fnd_nxt  = vic_fnd_r;
    vic_idx_nxt  = vic_idx_r;
    vic_age_nxt  = vic_age_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = p_idx_r;
    act_set      = 1'b0;
    act_clr      = 1'b0;
    act_idx      = p_idx_r;
    emit         = 1'b0;
    e_status     = ST_READ;
    e_slot_idx   = p_idx_r;
    e_slot_use   = 1'b0;
    e_entry      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cnt_nxt      = '0;
        free_fnd_nxt = 1'b0;
        vic_fnd_nxt  = 1'b0;
        case (cur_r.op)
          OP_READ: begin
            emit      = 1'b1;
            e_status  = ST_READ;
            e_entry   = rs_in && act_q_r;
            state_nxt = S_IDLE;
          end
          OP_SWEEP: state_nxt = S_SCAN;
          default: begin
            if (cur_r.origin == ORG_ANNOUNCE &&
                64'(ann_age) < 64'(gap_r)) begin
              emit      = 1'b1;
              e_status  = ST_RATELIM;
              state_nxt = S_IDLE;
            end else begin
              if (cur_r.origin == ORG_ANNOUNCE) last_nxt = now_t;
              state_nxt = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        // issue the next slot read
        if (cnt_r != NSLOTS) begin
          p_vld_nxt = 1'b1;
          p_idx_nxt = cnt_r[SW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
        end
        // examine the slot read last cycle
        if (p_vld_r) begin
          if (cur_r.op == OP_SWEEP) begin
            if (act_q_r && q_org != ORG_STATIC && 64'(age_q) > 64'(expiry_r)) begin
              act_clr  = 1'b1;
              live_nxt = live_r - 1'b1;
            end
          end else if (act_q_r && q_addr == cur_r.addr && q_port == cur_r.port) begin
            mem_we     = 1'b1;
            emit       = 1'b1;
            e_status   = ST_UPDATED;
            e_slot_use = 1'b1;
            state_nxt  = S_IDLE;
          end else if (!act_q_r) begin
            if (!free_fnd_r) begin
              free_fnd_nxt = 1'b1;
              free_idx_nxt = p_idx_r;
            end
          end else if (q_org != ORG_STATIC) begin
            if (!vic_fnd_r || age_q > vic_age_r) begin
              vic_fnd_nxt = 1'b1;
              vic_idx_nxt = p_idx_r;
              vic_age_nxt = age_q;
            end
          end
        end else if (cnt_r == NSLOTS) begin
          // scan complete
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (cur_r.op == OP_SWEEP) begin
            e_status = ST_SWEPT;
          end else if (free_fnd_r) begin
            e_status   = ST_INSERT;
            e_slot_use = 1'b1;
            e_slot_idx = free_idx_r;
            mem_we     = 1'b1;
            mem_wa     = free_idx_r;
            act_set    = 1'b1;
            act_idx    = free_idx_r;
            live_nxt   = live_r + 1'b1;
          end else if (vic_fnd_r) begin
            e_status   = ST_EVICT;
            e_slot_use = 1'b1;
            e_slot_idx = vic_idx_r;
            mem_we     = 1'b1;
            mem_wa     = vic_idx_r;
          end else begin
            e_status = ST_FULL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= wr_data;
    mem_q_r <= mem[rd_addr];
    act_q_r <= active_r[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cnt_r      <= cnt_nxt;
    p_idx_r    <= p_idx_nxt;
    free_fnd_r <= free_fnd_nxt;
    free_idx_r <= free_idx_nxt;
    vic_fnd_r  <= vic_fnd_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_age_r  <= vic_age_nxt;
  end

  assign slot_ext = 32'(e_slot_idx);
  assign live_ext = 32'(live_nxt);

  // control state, config and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_vld_r     <= 1'b0;
      active_r    <= '0;
      live_r      <= '0;
      last_r      <= '0;
      expiry_r    <= EXPIRY_RST;
      gap_r       <= GAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= p_vld_nxt;
      live_r  <= live_nxt;
      last_r  <= last_nxt;
      if (act_set) active_r[act_idx] <= 1'b1;
      if (act_clr) active_r[act_idx] <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_EXPIRY) expiry_r <= cfg_data;
        else expiry_r <= expiry_r;
        if (cfg_index == CFG_GAP) gap_r <= cfg_data;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status        <= e_status;
      out_active_count  <= live_ext[8:0];
      out_slot          <= (e_status == ST_READ) ? cur_r.rslot :
                           e_slot_use ? slot_ext[7:0] : 8'd0;
      out_entry_valid   <= e_entry;
      out_entry_address <= e_entry ? q_addr : 32'd0;
      out_entry_port    <= e_entry ? q_port : 16'd0;
      out_entry_origin  <= e_entry ? q_org : 2'd0;
    end
  end

  assign out_valid = out_valid_r;

  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r) else $error("result pending while busy");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(live_r) == 32'($countones(active_r))) else $error("live count mismatch");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !out_valid_r) else $error("result overwritten");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_DISP)) else $error("pop without dispatch");

endmodule

>>> rtl/peer_table_lru_aging_top.sv
// Peer table with ageing, LRU eviction and rate-limited announces: top level.
// A read gives its result from the dispatch state without a scan; an upsert or sweep scans
// the table, one slot read a cycle, and an upsert stops early on a match.
// The back end takes one item at a time: it waits for its result to be taken before
// popping the next beat.
// Reset (synchronous, rst_n low): clears valid bits, count, queue, announce time and
// loads config defaults; entry memory is not cleared.
module peer_table_lru_aging_top #(
  parameter int PEER_SLOTS = 256,
  parameter int TIME_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_peer_address,
  input  logic [15:0] in_peer_port,
  input  logic [1:0]  in_origin_kind,
  input  logic [31:0] in_now_ticks,
  input  logic [7:0]  in_read_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_slot,
  output logic [31:0] out_entry_address,
  output logic [15:0] out_entry_port,
  output logic [1:0]  out_entry_origin,
  output logic        out_entry_valid,
  output logic [8:0]  out_active_count
);
  import ptla_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  ptla_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_peer_address, .in_peer_port,
    .in_origin_kind, .in_now_ticks, .in_read_slot, .q_valid, .q_item, .q_pop
  );

  ptla_back #(.PEER_SLOTS(PEER_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_status, .out_slot, .out_entry_address,
    .out_entry_port, .out_entry_origin, .out_entry_valid, .out_active_count
  );

endmodule

>>> test/peer_table_lru_aging_top_tb.sv
// Self-checking testbench for the peer table with ageing and LRU eviction.
// Depends on rtl/ptla_pkg.sv and rtl/peer_table_lru_aging_top.sv.
`timescale 1ns / 100ps

module peer_table_lru_aging_top_tb;
  import ptla_pkg::*;

  localparam int SLOTS = 256;
  localparam int HOLD_OFF = 3000;
  localparam int WATCH_LIMIT = 40000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [15:0] port;
    logic [1:0]  origin;
    logic [31:0] now;
    logic [7:0]  rslot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] addr;
    logic [15:0] port;
    logic [1:0]  origin;
    logic        valid;
    logic [8:0]  count;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_EXPIRY;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_peer_address = '0;
  logic [15:0] in_peer_port = '0;
  logic [1:0]  in_origin_kind = '0;
  logic [31:0] in_now_ticks = '0;
  logic [7:0]  in_read_slot = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_slot;
  logic [31:0] out_entry_address;
  logic [15:0] out_entry_port;
  logic [1:0]  out_entry_origin;
  logic        out_entry_valid;
  logic [8:0]  out_active_count;

  peer_table_lru_aging_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the table
  logic [31:0] tbl_addr [SLOTS];
  logic [15:0] tbl_port [SLOTS];
  logic [31:0] tbl_stamp [SLOTS];
  logic [1:0]  tbl_origin [SLOTS];
  logic        tbl_active [SLOTS];
  logic [31:0] last_announce;
  logic [8:0]  live;
  logic [31:0] expiry_q, gap_q;

  req_t  pending_beats[$];
  resp_t expected_resp[$];
  int    errors = 0;
  int    send_idle = 33, recv_idle = 75;
  bit    hold_recv = 0;
  int    hold_cnt = 0;
  int    quiet = 0;
  logic [31:0] clock_ticks = 32'd1000;
  logic [31:0] key_addr [16];
  logic [15:0] key_port [16];
  logic  in_stall_q = 1'b0;

  function automatic resp_t predict_table(req_t r);
    resp_t o;
    logic [1:0]  org;
    logic [31:0] a, vage;
    int fr, vic;
    o = '0;
    if (r.kind == OP_UPSERT) begin
      org = (r.origin == 2'd3) ? ORG_EXCHANGE : r.origin;
      if (org == ORG_ANNOUNCE) begin
        if (r.now - last_announce < gap_q) begin
          o.status = ST_RATELIM; o.count = live; return o;
        end
        last_announce = r.now;
      end
      fr = -1; vic = -1; vage = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_active[i] && tbl_addr[i] == r.addr && tbl_port[i] == r.port) begin
          tbl_stamp[i] = r.now; tbl_origin[i] = org;
          o.status = ST_UPDATED; o.slot = i[7:0]; o.count = live; return o;
        end
        if (!tbl_active[i]) begin
          if (fr < 0) fr = i;
        end else if (tbl_origin[i] != ORG_STATIC) begin
          a = r.now - tbl_stamp[i];
          if (vic < 0 || a > vage) begin vic = i; vage = a; end
        end
      end
      if (fr >= 0) begin
        o.status = ST_INSERT; live++;
      end else if (vic >= 0) begin
        o.status = ST_EVICT; fr = vic;
      end else begin
        o.status = ST_FULL; o.count = live; return o;
      end
      tbl_addr[fr] = r.addr; tbl_port[fr] = r.port; tbl_stamp[fr] = r.now;
      tbl_origin[fr] = org; tbl_active[fr] = 1'b1;
      o.slot = fr[7:0];
    end else if (r.kind == OP_SWEEP) begin
      for (int i = 0; i < SLOTS; i++)
        if (tbl_active[i] && tbl_origin[i] != ORG_STATIC &&
            r.now - tbl_stamp[i] > expiry_q) begin
          tbl_active[i] = 1'b0; live--;
        end
      o.status = ST_SWEPT;
    end else begin
      // kind three behaves as a read
      o.status = ST_READ; o.slot = r.rslot;
      if (tbl_active[r.rslot]) begin
        o.addr = tbl_addr[r.rslot]; o.port = tbl_port[r.rslot];
        o.origin = tbl_origin[r.rslot]; o.valid = 1'b1;
      end
    end
    o.count = live;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Driver: new beat offered on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall_q) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          req_t b;
          b = pending_beats.pop_front();
          in_valid <= 1'b1; in_kind <= b.kind; in_peer_address <= b.addr;
          in_peer_port <= b.port; in_origin_kind <= b.origin;
          in_now_ticks <= b.now; in_read_slot <= b.rslot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold-off counted here
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_recv && hold_cnt < HOLD_OFF) begin
        out_stall <= 1'b1; hold_cnt <= hold_cnt + 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Acceptance seen at the rising edge, latched for the driver
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    in_stall_q <= in_valid && in_stall;
    if (rst_n && in_valid && !in_stall) begin
      req_t r;
      r = {in_kind, in_peer_address, in_peer_port, in_origin_kind,
           in_now_ticks, in_read_slot};
      expected_resp.push_back(predict_table(r));
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      resp_t w;
      moved = 1'b1;
      if (expected_resp.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_status), 32'd0);
      end else begin
        w = expected_resp.pop_front();
        if (out_status != w.status)
          report_mismatch("status", 32'(out_status), 32'(w.status));
        if (out_slot != w.slot) report_mismatch("slot", 32'(out_slot), 32'(w.slot));
        if (out_entry_address != w.addr)
          report_mismatch("entry_address", out_entry_address, w.addr);
        if (out_entry_port != w.port)
          report_mismatch("entry_port", 32'(out_entry_port), 32'(w.port));
        if (out_entry_origin != w.origin)
          report_mismatch("entry_origin", 32'(out_entry_origin), 32'(w.origin));
        if (out_entry_valid != w.valid)
          report_mismatch("entry_valid", 32'(out_entry_valid), 32'(w.valid));
        if (out_active_count != w.count)
          report_mismatch("active_count", 32'(out_active_count), 32'(w.count));
      end
    end
    quiet <= moved ? 0 : quiet + 1;
  end

  // Watchdog on stalled progress
  always @(posedge clk) begin
    if (quiet > WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_beat(logic [1:0] k, logic [31:0] a, logic [15:0] p,
                            logic [1:0] o, logic [31:0] t, logic [7:0] s);
    pending_beats.push_back({k, a, p, o, t, s});
  endtask

  task automatic drain;
    while (pending_beats.size() > 0 || in_valid || expected_resp.size() > 0)
      @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EXPIRY) expiry_q = val; else gap_q = val;
  endtask

  task automatic random_phase(int n);
    logic [1:0] o;
    int kk;
    for (int i = 0; i < n; i++) begin
      clock_ticks += $urandom_range(0, 400);
      o = 2'($urandom_range(0, 3));
      if ($urandom_range(9) == 0) begin
        queue_beat(2'($urandom), $urandom, 16'($urandom), o, $urandom, 8'($urandom));
      end else if ($urandom_range(9) < 6) begin
        kk = $urandom_range(15);
        queue_beat(OP_UPSERT, key_addr[kk], key_port[kk], o, clock_ticks, 0);
      end else if ($urandom_range(3) == 0) begin
        queue_beat(OP_SWEEP, 0, 0, 0, clock_ticks, 0);
      end else begin
        queue_beat(OP_READ, 0, 0, 0, 0, 8'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_active[i] = 1'b0;
    last_announce = 0; live = 0;
    expiry_q = EXPIRY_RST; gap_q = GAP_RST;
    for (int i = 0; i < 16; i++) begin
      key_addr[i] = $urandom; key_port[i] = 16'($urandom);
    end
    key_addr[0] = '1; key_port[0] = '1; key_addr[1] = '0; key_port[1] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: extremes, each kind, rate limit, wrap, kind and origin three
    queue_beat(OP_READ, 0, 0, 0, 0, 8'hff);
    queue_beat(OP_UPSERT, '1, '1, ORG_ANNOUNCE, 32'd50, 0);
    queue_beat(OP_UPSERT, '1, '1, ORG_ANNOUNCE, 32'd200, 0);
    queue_beat(OP_UPSERT, '1, '1, ORG_ANNOUNCE, 32'd250, 0);
    queue_beat(OP_UPSERT, 0, 0, ORG_STATIC, 32'hffff_fff0, 0);
    queue_beat(OP_UPSERT, 32'h1234, 16'h8000, 2'd3, 32'h10, 0);
    queue_beat(OP_READ, 0, 0, 0, 0, 0);
    queue_beat(OP_READ, 0, 0, 0, 0, 1);
    queue_beat(OP_READ, 0, 0, 0, 0, 2);
    queue_beat(2'd3, 0, 0, 0, 0, 3);
    queue_beat(OP_UPSERT, 0, 0, ORG_EXCHANGE, 32'h20, 0);
    queue_beat(OP_SWEEP, 0, 0, 0, 32'h7fff_ffff, 0);
    queue_beat(OP_READ, 0, 0, 0, 0, 0);
    queue_beat(OP_SWEEP, 0, 0, 0, 32'h8000_0000, 0);
    drain();

    // Fill the table with static and exchange peers, then force eviction and full
    write_reg(CFG_GAP, 32'd0);
    for (int i = 0; i < SLOTS; i++)
      queue_beat(OP_UPSERT, 32'h0a00_0000 + i, i[15:0],
                 (i < 250) ? ORG_STATIC : ORG_EXCHANGE, 32'd5000 + i[31:0] % 3, 0);
    send_idle = 0; recv_idle = 0; hold_recv = 1;
    queue_beat(OP_UPSERT, 32'hdead, 16'h1, ORG_EXCHANGE, 32'd6000, 0);
    queue_beat(OP_UPSERT, 32'hdead, 16'h2, ORG_ANNOUNCE, 32'd6001, 0);
    drain();
    hold_recv = 0;
    for (int i = 0; i < 6; i++)
      queue_beat(OP_UPSERT, 32'h0a00_0000 + 250 + i, 16'(i + 250), ORG_STATIC,
                 32'd7000, 0);
    queue_beat(OP_UPSERT, 32'hbeef, 16'h3, ORG_EXCHANGE, 32'd7001, 0);
    queue_beat(OP_UPSERT, 32'hbeef, 16'h4, ORG_ANNOUNCE, 32'd7002, 0);
    queue_beat(OP_READ, 0, 0, 0, 0, 8'd255);
    drain();
    // Demote all to exchange so a sweep empties the table
    write_reg(CFG_EXPIRY, 32'd0);
    for (int i = 0; i < SLOTS; i++)
      queue_beat(OP_UPSERT, 32'h0a00_0000 + i, i[15:0], ORG_EXCHANGE, 32'd8000, 0);
    queue_beat(OP_SWEEP, 0, 0, 0, 32'd8001, 0);
    drain();

    // Random phases under varied register settings and idling
    send_idle = 33; recv_idle = 75;
    write_reg(CFG_EXPIRY, 32'd3000); write_reg(CFG_GAP, 32'd150);
    random_phase(400); drain();
    send_idle = 75; recv_idle = 33;
    write_reg(CFG_EXPIRY, '1); write_reg(CFG_GAP, '1);
    random_phase(200); drain();
    write_reg(CFG_EXPIRY, 32'd800); write_reg(CFG_GAP, 32'd0);
    random_phase(150); drain();
    send_idle = 0; recv_idle = 0;
    write_reg(CFG_EXPIRY, EXPIRY_RST); write_reg(CFG_GAP, GAP_RST);
    random_phase(250); drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
